### rtl/dual_backlight_timed_blink_ctrl_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual backlight controller
// Concurrent checks on the top level, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef DUAL_BACKLIGHT_TIMED_BLINK_CTRL_TOP_ASSERT_SVH
`define DUAL_BACKLIGHT_TIMED_BLINK_CTRL_TOP_ASSERT_SVH

// Same-cycle implication.
`define DBTBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DBTBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dbtbc_pkg.sv
// ----------------------------------------------------------------------------
// dbtbc_pkg
// Shared codes, tables and helpers of the dual backlight controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dbtbc_pkg;

    localparam int TIME_BITS_DEF = 16;
    localparam int LEVELS        = 16;

    localparam logic [6:0] DEFAULT_RAW = 7'd56;

    // Opcodes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ON     = 3'd1;
    localparam logic [2:0] OP_OFF    = 3'd2;
    localparam logic [2:0] OP_BLINK  = 3'd3;
    localparam logic [2:0] OP_TOGGLE = 3'd4;
    localparam logic [2:0] OP_BRIGHT = 3'd5;

    // Targets
    localparam logic [1:0] TGT_SCREEN = 2'd0;
    localparam logic [1:0] TGT_KEYS   = 2'd1;
    localparam logic [1:0] TGT_BOTH   = 2'd2;
    localparam logic [1:0] TGT_NONE   = 2'd3;

    // Channel status
    localparam logic [1:0] ST_OFF   = 2'd0;
    localparam logic [1:0] ST_ON    = 2'd1;
    localparam logic [1:0] ST_BLINK = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_BLINK_ARG = 2'd1;
    localparam logic [1:0] ERR_TARGET    = 2'd2;

    localparam logic [6:0] NORM_TAB [LEVELS] = '{
        7'd0,  7'd13, 7'd14, 7'd18, 7'd24, 7'd30, 7'd36, 7'd42,
        7'd48, 7'd54, 7'd60, 7'd66, 7'd72, 7'd78, 7'd84, 7'd90
    };

    localparam logic [6:0] LEVEL_TAB [LEVELS] = '{
        7'd0,  7'd13, 7'd17, 7'd23, 7'd29, 7'd35, 7'd41, 7'd47,
        7'd53, 7'd59, 7'd65, 7'd71, 7'd77, 7'd83, 7'd89, 7'd100
    };

    // Per-channel command and tick controls
    typedef struct packed {
        logic tick;
        logic upd;
        logic flip;
        logic on_val;
        logic blink_val;
    } t_chan_ctl;

    // Clamp a tick count to what a timer of the given width can hold.
    function automatic logic [15:0] sat_ticks(input logic [15:0] v, input int bits);
        logic [15:0] lim;
        lim = (bits >= 16) ? 16'hFFFF : 16'((32'd1 << bits) - 32'd1);
        return (v > lim) ? lim : v;
    endfunction

    // Map a raw brightness back to a level: one above the highest table hit.
    function automatic logic [4:0] norm_level(input logic [6:0] b);
        logic [4:0] res;
        res = 5'd1;
        for (int i = 1; i < LEVELS; i++) begin
            if (b >= NORM_TAB[i]) begin
                res = 5'(i + 1);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/dbtbc_chan.sv
// ----------------------------------------------------------------------------
// dbtbc_chan
// One backlight channel: current and lasting setting, override and blink timers.
// ----------------------------------------------------------------------------
`default_nettype none

module dbtbc_chan #(
    parameter int TIME_BITS = dbtbc_pkg::TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dbtbc_pkg::t_chan_ctl i_ctl,
    input  wire logic [15:0]          i_dur,
    input  wire logic [15:0]          i_per_on,
    input  wire logic [15:0]          i_per_off,
    output logic                      o_on_nxt,
    output logic                      o_blink_nxt
);

    localparam logic [TIME_BITS-1:0] T_ONE = {{(TIME_BITS-1){1'b0}}, 1'b1};

    function automatic logic [TIME_BITS-1:0] ticks(input logic [15:0] v);
        logic [31:0] w;
        w = {16'b0, dbtbc_pkg::sat_ticks(v, TIME_BITS)};
        return w[TIME_BITS-1:0];
    endfunction

    logic                 r_on, r_blink, r_on_k, r_blink_k;
    logic [15:0]          r_per_on, r_per_off, r_per_on_k, r_per_off_k;
    logic                 r_ovr_act, r_blk_act;
    logic [TIME_BITS-1:0] r_ovr_cnt, r_blk_cnt;

    logic                 n_on, n_blink, n_on_k, n_blink_k;
    logic [15:0]          n_per_on, n_per_off, n_per_on_k, n_per_off_k;
    logic                 n_ovr_act, n_blk_act;
    logic [TIME_BITS-1:0] n_ovr_cnt, n_blk_cnt;

    logic                 ovr_exp, blk_exp, cmd_on;
    logic [TIME_BITS-1:0] kept_ld, flip_ld, cmd_ld, dur_ld;

    assign ovr_exp = r_ovr_act && (r_ovr_cnt == T_ONE);
    assign blk_exp = r_blk_act && (r_blk_cnt == T_ONE);
    assign cmd_on  = i_ctl.flip ? !r_on : i_ctl.on_val;
    assign kept_ld = ticks(r_on_k ? r_per_on_k : r_per_off_k);
    assign flip_ld = ticks(!r_on ? r_per_on : r_per_off);
    assign cmd_ld  = ticks(cmd_on ? i_per_on : i_per_off);
    assign dur_ld  = ticks(i_dur);

    always_comb begin
        n_on        = r_on;
        n_blink     = r_blink;
        n_per_on    = r_per_on;
        n_per_off   = r_per_off;
        n_on_k      = r_on_k;
        n_blink_k   = r_blink_k;
        n_per_on_k  = r_per_on_k;
        n_per_off_k = r_per_off_k;
        n_ovr_act   = r_ovr_act;
        n_ovr_cnt   = r_ovr_cnt;
        n_blk_act   = r_blk_act;
        n_blk_cnt   = r_blk_cnt;
        if (i_ctl.tick) begin
            if (r_ovr_act) begin
                n_ovr_cnt = r_ovr_cnt - T_ONE;
            end
            if (r_blk_act) begin
                n_blk_cnt = r_blk_cnt - T_ONE;
            end
            if (ovr_exp) begin
                // revert to the lasting setting and restart blinking from it
                n_ovr_act = 1'b0;
                n_ovr_cnt = '0;
                n_on      = r_on_k;
                n_blink   = r_blink_k;
                n_per_on  = r_per_on_k;
                n_per_off = r_per_off_k;
                n_blk_act = r_blink_k && (kept_ld != '0);
                n_blk_cnt = r_blink_k ? kept_ld : '0;
            end else if (blk_exp) begin
                n_on      = !r_on;
                n_blk_act = (flip_ld != '0);
                n_blk_cnt = flip_ld;
            end
        end else if (i_ctl.upd) begin
            n_on      = cmd_on;
            n_blink   = i_ctl.blink_val;
            n_per_on  = i_per_on;
            n_per_off = i_per_off;
            if (i_dur == 16'd0) begin
                n_on_k      = cmd_on;
                n_blink_k   = i_ctl.blink_val;
                n_per_on_k  = i_per_on;
                n_per_off_k = i_per_off;
            end
            // a running blink countdown is kept
            if (i_ctl.blink_val) begin
                if (!r_blk_act) begin
                    n_blk_act = (cmd_ld != '0);
                    n_blk_cnt = cmd_ld;
                end
            end else begin
                n_blk_act = 1'b0;
                n_blk_cnt = '0;
            end
            n_ovr_act = (dur_ld != '0);
            n_ovr_cnt = dur_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on        <= 1'b1;
            r_blink     <= 1'b0;
            r_per_on    <= '0;
            r_per_off   <= '0;
            r_on_k      <= 1'b1;
            r_blink_k   <= 1'b0;
            r_per_on_k  <= '0;
            r_per_off_k <= '0;
            r_ovr_act   <= 1'b0;
            r_ovr_cnt   <= '0;
            r_blk_act   <= 1'b0;
            r_blk_cnt   <= '0;
        end else begin
            r_on        <= n_on;
            r_blink     <= n_blink;
            r_per_on    <= n_per_on;
            r_per_off   <= n_per_off;
            r_on_k      <= n_on_k;
            r_blink_k   <= n_blink_k;
            r_per_on_k  <= n_per_on_k;
            r_per_off_k <= n_per_off_k;
            r_ovr_act   <= n_ovr_act;
            r_ovr_cnt   <= n_ovr_cnt;
            r_blk_act   <= n_blk_act;
            r_blk_cnt   <= n_blk_cnt;
        end
    end

    assign o_on_nxt    = n_on;
    assign o_blink_nxt = n_blink;

endmodule

`default_nettype wire

### rtl/dual_backlight_timed_blink_ctrl_top.sv
// ----------------------------------------------------------------------------
// dual_backlight_timed_blink_ctrl_top
// Screen and keypad backlight controller with timed overrides and blinking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) takes one command per transfer: a tick
//   (opcode 0) or an on, off, blink, toggle or brightness command. Each input
//   transfer yields exactly one result transfer on the output channel
//   (o_valid / i_stall) with lit bits, channel status, raw and normalized
//   brightness, and an error code.
//   Result path: an input transfer loads the input register; the item then
//   moves on to the result register, which drives o_valid and the result
//   fields (one input register, one result register).
//   Throughput: one transfer per cycle while i_stall is low; the whole state
//   update for an item is done in the cycle between the two registers, so
//   back-to-back items flow without bubbles.
//   Stall: while i_stall holds a result, the input register may still take
//   one more item; o_stall rises only when both registers are full and i_stall is high.
//   Reset (i_rst_n low, synchronous): both channels lit and not blinking,
//   all five timers stopped, brightness 56, both registers empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_backlight_timed_blink_ctrl_top_assert.svh"

module dual_backlight_timed_blink_ctrl_top #(
    parameter int TIME_BITS = dbtbc_pkg::TIME_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [1:0]  i_target,
    input  wire logic [15:0] i_duration,
    input  wire logic [15:0] i_on_time,
    input  wire logic [15:0] i_off_time,
    input  wire logic [7:0]  i_brightness_level,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_screen_lit,
    output logic             o_keys_lit,
    output logic [1:0]       o_screen_status,
    output logic [1:0]       o_keys_status,
    output logic [6:0]       o_brightness_raw,
    output logic [4:0]       o_brightness_norm,
    output logic [1:0]       o_error_code
);

    localparam logic [TIME_BITS-1:0] T_ONE = {{(TIME_BITS-1){1'b0}}, 1'b1};

    function automatic logic [TIME_BITS-1:0] ticks(input logic [15:0] v);
        logic [31:0] w;
        w = {16'b0, dbtbc_pkg::sat_ticks(v, TIME_BITS)};
        return w[TIME_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Handshake: input register and result register
    // ------------------------------------------------------------------
    logic r_in_vld, r_out_vld;
    logic out_ready, adv, in_take;

    // result register can load when empty or when its transfer completes
    assign out_ready = !r_out_vld || !i_stall;
    // advance the held item into the result register
    assign adv       = r_in_vld && out_ready;
    assign o_stall   = r_in_vld && !out_ready;
    assign in_take   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (out_ready) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // input payload, held while the item waits
    logic [2:0]  r_op;
    logic [1:0]  r_tgt;
    logic [15:0] r_dur, r_on_t, r_off_t;
    logic [7:0]  r_lvl;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op    <= i_opcode;
            r_tgt   <= i_target;
            r_dur   <= i_duration;
            r_on_t  <= i_on_time;
            r_off_t <= i_off_time;
            r_lvl   <= i_brightness_level;
        end
    end

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    dbtbc_pkg::t_chan_ctl scr_ctl, key_ctl;
    logic [15:0]          eff_dur, per_on, per_off;
    logic                 blink_bad, bri_tick, bri_cmd;
    logic [1:0]           n_err;

    // off is always lasting
    assign eff_dur   = (r_op == dbtbc_pkg::OP_OFF) ? 16'd0 : r_dur;
    assign blink_bad = (r_op == dbtbc_pkg::OP_BLINK) &&
                       ((r_on_t == 16'd0) || (r_off_t == 16'd0));
    // only a blink command carries periods
    assign per_on    = (r_op == dbtbc_pkg::OP_BLINK) ? r_on_t  : 16'd0;
    assign per_off   = (r_op == dbtbc_pkg::OP_BLINK) ? r_off_t : 16'd0;

    always_comb begin
        scr_ctl  = '0;
        key_ctl  = '0;
        bri_tick = 1'b0;
        bri_cmd  = 1'b0;
        n_err    = dbtbc_pkg::ERR_OK;
        if (adv) begin
            case (r_op)
                dbtbc_pkg::OP_TICK: begin
                    scr_ctl.tick = 1'b1;
                    key_ctl.tick = 1'b1;
                    bri_tick     = 1'b1;
                end
                dbtbc_pkg::OP_ON, dbtbc_pkg::OP_OFF,
                dbtbc_pkg::OP_BLINK, dbtbc_pkg::OP_TOGGLE: begin
                    if (blink_bad) begin
                        n_err = dbtbc_pkg::ERR_BLINK_ARG;
                    end else begin
                        scr_ctl.upd = (r_tgt inside {dbtbc_pkg::TGT_SCREEN,
                                                     dbtbc_pkg::TGT_BOTH});
                        key_ctl.upd = (r_tgt inside {dbtbc_pkg::TGT_KEYS,
                                                     dbtbc_pkg::TGT_BOTH});
                        if (r_tgt == dbtbc_pkg::TGT_NONE) begin
                            n_err = dbtbc_pkg::ERR_TARGET;
                        end
                    end
                    scr_ctl.flip      = (r_op == dbtbc_pkg::OP_BLINK) ||
                                        (r_op == dbtbc_pkg::OP_TOGGLE);
                    scr_ctl.on_val    = (r_op == dbtbc_pkg::OP_ON);
                    scr_ctl.blink_val = (r_op == dbtbc_pkg::OP_BLINK);
                    key_ctl.flip      = scr_ctl.flip;
                    key_ctl.on_val    = scr_ctl.on_val;
                    key_ctl.blink_val = scr_ctl.blink_val;
                end
                dbtbc_pkg::OP_BRIGHT: begin
                    bri_cmd = 1'b1;
                end
                default: begin
                    // unused opcodes only report the state
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Channels
    // ------------------------------------------------------------------
    logic scr_on_nxt, scr_blink_nxt, key_on_nxt, key_blink_nxt;

    dbtbc_chan #(
        .TIME_BITS (TIME_BITS)
    ) u_screen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scr_ctl),
        .i_dur       (eff_dur),
        .i_per_on    (per_on),
        .i_per_off   (per_off),
        .o_on_nxt    (scr_on_nxt),
        .o_blink_nxt (scr_blink_nxt)
    );

    dbtbc_chan #(
        .TIME_BITS (TIME_BITS)
    ) u_keys (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (key_ctl),
        .i_dur       (eff_dur),
        .i_per_on    (per_on),
        .i_per_off   (per_off),
        .o_on_nxt    (key_on_nxt),
        .o_blink_nxt (key_blink_nxt)
    );

    // ------------------------------------------------------------------
    // Brightness with its own override timer
    // ------------------------------------------------------------------
    logic [6:0]           r_bri_now, r_bri_kept, n_bri_now, n_bri_kept, bri_val;
    logic                 r_bri_ovr_act, n_bri_ovr_act;
    logic [TIME_BITS-1:0] r_bri_ovr_cnt, n_bri_ovr_cnt, bri_ld;
    logic [15:0]          bri_dur;

    // level zero restores the lasting value as lasting
    assign bri_dur = (r_lvl == 8'd0) ? 16'd0 : r_dur;
    assign bri_ld  = ticks(bri_dur);

    always_comb begin
        if (r_lvl == 8'd0) begin
            bri_val = r_bri_kept;
        end else if (r_lvl <= 8'(dbtbc_pkg::LEVELS)) begin
            bri_val = dbtbc_pkg::LEVEL_TAB[4'(r_lvl - 8'd1)];
        end else begin
            bri_val = dbtbc_pkg::DEFAULT_RAW;
        end
    end

    always_comb begin
        n_bri_now     = r_bri_now;
        n_bri_kept    = r_bri_kept;
        n_bri_ovr_act = r_bri_ovr_act;
        n_bri_ovr_cnt = r_bri_ovr_cnt;
        if (bri_tick && r_bri_ovr_act) begin
            if (r_bri_ovr_cnt == T_ONE) begin
                // override ran out: drop back to the lasting value
                n_bri_ovr_act = 1'b0;
                n_bri_ovr_cnt = '0;
                n_bri_now     = r_bri_kept;
            end else begin
                n_bri_ovr_cnt = r_bri_ovr_cnt - T_ONE;
            end
        end else if (bri_cmd) begin
            n_bri_now = bri_val;
            if (bri_dur == 16'd0) begin
                n_bri_kept = bri_val;
            end
            n_bri_ovr_act = (bri_ld != '0);
            n_bri_ovr_cnt = bri_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bri_now     <= dbtbc_pkg::DEFAULT_RAW;
            r_bri_kept    <= dbtbc_pkg::DEFAULT_RAW;
            r_bri_ovr_act <= 1'b0;
            r_bri_ovr_cnt <= '0;
        end else begin
            r_bri_now     <= n_bri_now;
            r_bri_kept    <= n_bri_kept;
            r_bri_ovr_act <= n_bri_ovr_act;
            r_bri_ovr_cnt <= n_bri_ovr_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Result register: report the state the item leaves behind
    // ------------------------------------------------------------------
    logic       r_scr_lit, r_key_lit;
    logic [1:0] r_scr_st, r_key_st, r_err;
    logic [6:0] r_raw;
    logic [4:0] r_norm;
    logic [1:0] n_scr_st, n_key_st;

    assign n_scr_st = scr_blink_nxt ? dbtbc_pkg::ST_BLINK :
                      (scr_on_nxt ? dbtbc_pkg::ST_ON : dbtbc_pkg::ST_OFF);
    assign n_key_st = key_blink_nxt ? dbtbc_pkg::ST_BLINK :
                      (key_on_nxt ? dbtbc_pkg::ST_ON : dbtbc_pkg::ST_OFF);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_scr_lit <= scr_on_nxt;
            r_key_lit <= key_on_nxt;
            r_scr_st  <= n_scr_st;
            r_key_st  <= n_key_st;
            r_raw     <= n_bri_now;
            r_norm    <= dbtbc_pkg::norm_level(n_bri_now);
            r_err     <= n_err;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_screen_lit      = r_scr_lit;
    assign o_keys_lit        = r_key_lit;
    assign o_screen_status   = r_scr_st;
    assign o_keys_status     = r_key_st;
    assign o_brightness_raw  = r_raw;
    assign o_brightness_norm = r_norm;
    assign o_error_code      = r_err;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DBTBC_ASSERT_NEXT(a_adv_fills_result, i_clk, i_rst_n, adv, r_out_vld,
        "advanced item did not reach the result register")
    `DBTBC_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall,
        r_in_vld && r_out_vld && i_stall,
        "input stalled while a register could take the item")
    `DBTBC_ASSERT_NOW(a_bri_timer_nonzero, i_clk, i_rst_n, r_bri_ovr_act,
        r_bri_ovr_cnt != '0,
        "brightness override active with an empty count")

endmodule

`default_nettype wire

### tb/backlight_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// backlight_check_pkg
// Command and report types, a lamp-state predictor and the report scoreboard
// for the dual backlight controller.
// ----------------------------------------------------------------------------

package backlight_check_pkg;

    import dbtbc_pkg::*;

    // Opcodes the block treats as no-ops
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam logic [6:0] RAW_AT_RESET = 7'd56;

    // Raw value per brightness level, and the lower bound of each level
    localparam logic [6:0] LEVEL_RAW [16] = '{
        7'd0,  7'd13, 7'd17, 7'd23, 7'd29, 7'd35, 7'd41, 7'd47,
        7'd53, 7'd59, 7'd65, 7'd71, 7'd77, 7'd83, 7'd89, 7'd100
    };
    localparam logic [6:0] LEVEL_FLOOR [16] = '{
        7'd0,  7'd13, 7'd14, 7'd18, 7'd24, 7'd30, 7'd36, 7'd42,
        7'd48, 7'd54, 7'd60, 7'd66, 7'd72, 7'd78, 7'd84, 7'd90
    };

    typedef enum int {
        MODE_DARK,
        MODE_LIT,
        MODE_FLIP
    } lamp_mode_e;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  target;
        logic [15:0] duration;
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [7:0]  level;
    } lamp_cmd_t;

    typedef struct packed {
        logic       screen_lit;
        logic       keys_lit;
        logic [1:0] screen_status;
        logic [1:0] keys_status;
        logic [6:0] brightness_raw;
        logic [4:0] brightness_norm;
        logic [1:0] error_code;
    } lamp_report_t;

    class backlight_checker;

        // channel index 0 is the screen, 1 the keys; hold timer 2 is brightness
        bit          lit_now [2];
        bit          blink_now [2];
        bit [31:0]   period_now [2];
        bit          lit_kept [2];
        bit          blink_kept [2];
        bit [31:0]   period_kept [2];
        bit          hold_run [3];
        bit [15:0]   hold_left [3];
        bit          flash_run [2];
        bit [15:0]   flash_left [2];
        bit [6:0]    raw_now;
        bit [6:0]    raw_kept;

        lamp_report_t pending_reports [$];

        int unsigned mismatches;
        int unsigned reports_checked;
        int unsigned commands_taken;
        int unsigned ticks_taken;
        int unsigned blink_flips;
        int unsigned override_reverts;
        int unsigned error_reports;

        function new();
            for (int ch = 0; ch < 2; ch++) begin
                lit_now[ch]     = 1'b1;
                blink_now[ch]   = 1'b0;
                period_now[ch]  = '0;
                lit_kept[ch]    = 1'b1;
                blink_kept[ch]  = 1'b0;
                period_kept[ch] = '0;
                flash_run[ch]   = 1'b0;
                flash_left[ch]  = '0;
            end
            for (int i = 0; i < 3; i++) begin
                hold_run[i]  = 1'b0;
                hold_left[i] = '0;
            end
            raw_now  = RAW_AT_RESET;
            raw_kept = RAW_AT_RESET;
        endfunction

        // Timers are 16 bits wide, so every 16-bit count fits without clamping.
        function void arm_hold(int idx, bit [15:0] ticks);
            hold_run[idx]  = (ticks != 0);
            hold_left[idx] = ticks;
        endfunction

        function void arm_flash(int ch, bit [15:0] ticks);
            flash_run[ch]  = (ticks != 0);
            flash_left[ch] = ticks;
        endfunction

        // Restart idle blink timers of blinking channels; stop the others.
        function void sync_flash();
            for (int ch = 0; ch < 2; ch++) begin
                if (blink_now[ch]) begin
                    if (!flash_run[ch]) begin
                        arm_flash(ch, lit_now[ch] ? period_now[ch][31:16]
                                                  : period_now[ch][15:0]);
                    end
                end else begin
                    arm_flash(ch, '0);
                end
            end
        endfunction

        function void set_channel(int ch, lamp_mode_e mode, bit [15:0] dur,
                                  bit [31:0] periods);
            lit_now[ch]    = (mode == MODE_FLIP) ? !lit_now[ch] : (mode == MODE_LIT);
            blink_now[ch]  = (mode == MODE_FLIP) && (periods[31:16] != 0);
            period_now[ch] = periods;
            if (dur == 0) begin
                lit_kept[ch]    = lit_now[ch];
                blink_kept[ch]  = blink_now[ch];
                period_kept[ch] = period_now[ch];
            end
        endfunction

        function void run_tick();
            for (int i = 0; i < 3; i++) begin
                if (hold_run[i] && hold_left[i] != 0) hold_left[i]--;
            end
            for (int ch = 0; ch < 2; ch++) begin
                if (flash_run[ch] && flash_left[ch] != 0) flash_left[ch]--;
            end
            // channel overrides expire first, screen before keys
            for (int ch = 0; ch < 2; ch++) begin
                if (hold_run[ch] && hold_left[ch] == 0) begin
                    arm_hold(ch, '0);
                    arm_flash(ch, '0);
                    lit_now[ch]    = lit_kept[ch];
                    blink_now[ch]  = blink_kept[ch];
                    period_now[ch] = period_kept[ch];
                    override_reverts++;
                    sync_flash();
                end
            end
            if (hold_run[2] && hold_left[2] == 0) begin
                arm_hold(2, '0);
                raw_now = raw_kept;
                override_reverts++;
                sync_flash();
            end
            for (int ch = 0; ch < 2; ch++) begin
                if (flash_run[ch] && flash_left[ch] == 0) begin
                    arm_flash(ch, '0);
                    lit_now[ch] = !lit_now[ch];
                    blink_flips++;
                    sync_flash();
                end
            end
        endfunction

        // Level = 1 + number of upper level floors that the raw value reaches.
        function logic [4:0] level_of(bit [6:0] raw);
            logic [4:0] lvl;
            lvl = 5'd1;
            for (int i = 1; i < 16; i++) begin
                if (raw >= LEVEL_FLOOR[i]) lvl++;
            end
            return lvl;
        endfunction

        function lamp_report_t apply_command(lamp_cmd_t c);
            lamp_report_t rep;
            lamp_mode_e   mode;
            bit [31:0]    periods;
            bit [15:0]    dur;
            bit [6:0]     raw;
            bit           scr;
            bit           key;
            bit           ok;
            logic [1:0]   err;
            scr = (c.target == TGT_SCREEN) || (c.target == TGT_BOTH);
            key = (c.target == TGT_KEYS) || (c.target == TGT_BOTH);
            err = ERR_OK;
            dur = c.duration;
            case (c.opcode)
                OP_TICK: begin
                    ticks_taken++;
                    run_tick();
                end
                OP_ON, OP_OFF, OP_BLINK, OP_TOGGLE: begin
                    mode    = MODE_LIT;
                    periods = '0;
                    ok      = 1'b1;
                    if (c.opcode == OP_OFF) begin
                        mode = MODE_DARK;
                        dur  = '0;
                    end else if (c.opcode == OP_BLINK) begin
                        if (c.on_time == 0 || c.off_time == 0) begin
                            ok  = 1'b0;
                            err = ERR_BLINK_ARG;
                        end
                        mode    = MODE_FLIP;
                        periods = {c.on_time, c.off_time};
                    end else if (c.opcode == OP_TOGGLE) begin
                        mode = MODE_FLIP;
                    end
                    if (ok) begin
                        if (scr) set_channel(0, mode, dur, periods);
                        if (key) set_channel(1, mode, dur, periods);
                        sync_flash();
                        if (scr) arm_hold(0, dur);
                        if (key) arm_hold(1, dur);
                        if (c.target == TGT_NONE) err = ERR_TARGET;
                    end
                end
                OP_BRIGHT: begin
                    raw = RAW_AT_RESET;
                    if (c.level == 0) begin
                        raw = raw_kept;
                        dur = '0;
                    end else if (c.level <= 16) begin
                        raw = LEVEL_RAW[c.level - 1];
                    end
                    raw_now = raw;
                    if (dur == 0) raw_kept = raw;
                    sync_flash();
                    arm_hold(2, dur);
                end
                default: ;
            endcase
            rep.screen_lit      = lit_now[0];
            rep.keys_lit        = lit_now[1];
            rep.screen_status   = blink_now[0] ? ST_BLINK : (lit_now[0] ? ST_ON : ST_OFF);
            rep.keys_status     = blink_now[1] ? ST_BLINK : (lit_now[1] ? ST_ON : ST_OFF);
            rep.brightness_raw  = raw_now;
            rep.brightness_norm = level_of(raw_now);
            rep.error_code      = err;
            if (err != ERR_OK) error_reports++;
            return rep;
        endfunction

        function void accept_command(lamp_cmd_t c);
            commands_taken++;
            pending_reports.push_back(apply_command(c));
        endfunction

        function void check_report(lamp_report_t got);
            lamp_report_t want;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] report with no command pending: %p", $time, got);
                end
                return;
            end
            want = pending_reports.pop_front();
            reports_checked++;
            if (got.screen_lit      !== want.screen_lit      ||
                got.keys_lit        !== want.keys_lit        ||
                got.screen_status   !== want.screen_status   ||
                got.keys_status     !== want.keys_status     ||
                got.brightness_raw  !== want.brightness_raw  ||
                got.brightness_norm !== want.brightness_norm ||
                got.error_code      !== want.error_code) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] report %0d mismatch", $time, reports_checked);
                    $display("    expected: lit %b/%b st %0d/%0d raw %0d norm %0d err %0d",
                             want.screen_lit, want.keys_lit, want.screen_status,
                             want.keys_status, want.brightness_raw,
                             want.brightness_norm, want.error_code);
                    $display("    actual:   lit %b/%b st %0d/%0d raw %0d norm %0d err %0d",
                             got.screen_lit, got.keys_lit, got.screen_status,
                             got.keys_status, got.brightness_raw,
                             got.brightness_norm, got.error_code);
                end
            end
        endfunction

        function int pending_count();
            return pending_reports.size();
        endfunction

    endclass

endpackage

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual backlight controller: a short directed
// command list, then random commands heavy in ticks, sent in bursts against
// a stalling receiver; every report is compared with a lamp-state predictor.
// ----------------------------------------------------------------------------

module tb;

    import dbtbc_pkg::*;
    import backlight_check_pkg::*;

    localparam int RANDOM_COMMANDS = 450;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_opcode = '0;
    logic [1:0]  i_target = '0;
    logic [15:0] i_duration = '0;
    logic [15:0] i_on_time = '0;
    logic [15:0] i_off_time = '0;
    logic [7:0]  i_brightness_level = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_screen_lit;
    logic        o_keys_lit;
    logic [1:0]  o_screen_status;
    logic [1:0]  o_keys_status;
    logic [6:0]  o_brightness_raw;
    logic [4:0]  o_brightness_norm;
    logic [1:0]  o_error_code;

    backlight_checker lamp_sb = new();

    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned stall_style = 0;
    int unsigned stall_span = 0;

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    dual_backlight_timed_blink_ctrl_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_target           (i_target),
        .i_duration         (i_duration),
        .i_on_time          (i_on_time),
        .i_off_time         (i_off_time),
        .i_brightness_level (i_brightness_level),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_screen_lit       (o_screen_lit),
        .o_keys_lit         (o_keys_lit),
        .o_screen_status    (o_screen_status),
        .o_keys_status      (o_keys_status),
        .o_brightness_raw   (o_brightness_raw),
        .o_brightness_norm  (o_brightness_norm),
        .o_error_code       (o_error_code)
    );

    // Abort a hung run; the limit is far above the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports still pending",
                     cycle_count, lamp_sb.pending_count());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver stall: pick a style for a random span of cycles, including
    // spans with no stall at all so full-rate streaming is exercised.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall = 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_style = $urandom_range(0, 3);
                stall_span  = $urandom_range(16, 80);
            end
            stall_span = stall_span - 1;
            case (stall_style)
                0: i_stall = 1'b0;
                1: i_stall = ($urandom_range(0, 3) == 0);
                2: i_stall = ($urandom_range(0, 3) != 0);
                default: i_stall = (cycle_count % 3 == 0);
            endcase
        end
    end

    // Check every result transfer against the oldest predicted report.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            lamp_sb.check_report('{
                screen_lit:      o_screen_lit,
                keys_lit:        o_keys_lit,
                screen_status:   o_screen_status,
                keys_status:     o_keys_status,
                brightness_raw:  o_brightness_raw,
                brightness_norm: o_brightness_norm,
                error_code:      o_error_code
            });
        end
    end

    function automatic lamp_cmd_t make_cmd(logic [2:0] op, logic [1:0] tgt,
                                           logic [15:0] dur, logic [15:0] on_t,
                                           logic [15:0] off_t, logic [7:0] lvl);
        lamp_cmd_t c;
        c.opcode   = op;
        c.target   = tgt;
        c.duration = dur;
        c.on_time  = on_t;
        c.off_time = off_t;
        c.level    = lvl;
        return c;
    endfunction

    // Mostly short blink periods; now and then zero (bad argument) or any value.
    function automatic logic [15:0] random_period();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return 16'($urandom);
        return 16'($urandom_range(1, 6));
    endfunction

    // Tick-heavy mix with short overrides so timers expire and blinks flip.
    function automatic lamp_cmd_t random_command();
        lamp_cmd_t   c;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)      c.opcode = OP_TICK;
        else if (r < 55) c.opcode = OP_ON;
        else if (r < 62) c.opcode = OP_OFF;
        else if (r < 75) c.opcode = OP_BLINK;
        else if (r < 84) c.opcode = OP_TOGGLE;
        else if (r < 96) c.opcode = OP_BRIGHT;
        else             c.opcode = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;

        r = $urandom_range(0, 9);
        if (r == 0)     c.target = TGT_NONE;
        else if (r < 4) c.target = TGT_SCREEN;
        else if (r < 7) c.target = TGT_KEYS;
        else            c.target = TGT_BOTH;

        r = $urandom_range(0, 9);
        if (r < 3)       c.duration = '0;
        else if (r < 8)  c.duration = 16'($urandom_range(1, 8));
        else if (r == 8) c.duration = 16'($urandom_range(9, 40));
        else             c.duration = 16'($urandom);

        c.on_time  = random_period();
        c.off_time = random_period();

        r = $urandom_range(0, 9);
        if (r == 0)      c.level = '0;
        else if (r == 1) c.level = 8'($urandom_range(17, 255));
        else             c.level = 8'($urandom_range(1, 16));
        return c;
    endfunction

    // Send one command; called at a falling edge, returns at a falling edge.
    // Between bursts drop valid for a random gap.
    task automatic send_command(lamp_cmd_t c);
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
        i_valid            = 1'b1;
        i_opcode           = c.opcode;
        i_target           = c.target;
        i_duration         = c.duration;
        i_on_time          = c.on_time;
        i_off_time         = c.off_time;
        i_brightness_level = c.level;
        // hold the payload until the block takes the transfer
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        lamp_sb.accept_command(c);
        burst_left = burst_left - 1;
        @(negedge i_clk);
    endtask

    initial begin
        lamp_cmd_t opening [$];

        // synchronous reset, released at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: reset state, unused opcodes, blinking, bad blink
        // arguments, unsupported target, override expiry, brightness levels,
        // restore of lasting brightness and the largest field values.
        opening.push_back(make_cmd(OP_TICK,    TGT_SCREEN, 16'd0,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_SPARE_A, TGT_BOTH,   16'd3,     16'd2,     16'd2,     8'd5));
        opening.push_back(make_cmd(OP_SPARE_B, TGT_NONE,   16'hFFFF,  16'hFFFF,  16'hFFFF,  8'hFF));
        opening.push_back(make_cmd(OP_BLINK,   TGT_SCREEN, 16'd0,     16'd1,     16'd2,     8'd0));
        opening.push_back(make_cmd(OP_TICK,    TGT_SCREEN, 16'd0,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_TICK,    TGT_KEYS,   16'd0,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_TICK,    TGT_NONE,   16'd0,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_BLINK,   TGT_KEYS,   16'd0,     16'd0,     16'd5,     8'd0));
        opening.push_back(make_cmd(OP_BLINK,   TGT_BOTH,   16'd4,     16'd3,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_BLINK,   TGT_NONE,   16'd0,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_ON,      TGT_NONE,   16'd2,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_OFF,     TGT_KEYS,   16'd0,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_ON,      TGT_KEYS,   16'd2,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_TICK,    TGT_BOTH,   16'd0,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_TICK,    TGT_BOTH,   16'd0,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_TOGGLE,  TGT_BOTH,   16'd0,     16'd7,     16'd7,     8'd0));
        opening.push_back(make_cmd(OP_OFF,     TGT_SCREEN, 16'd5,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_BRIGHT,  TGT_NONE,   16'd0,     16'd0,     16'd0,     8'd1));
        opening.push_back(make_cmd(OP_BRIGHT,  TGT_SCREEN, 16'd0,     16'd0,     16'd0,     8'd16));
        opening.push_back(make_cmd(OP_BRIGHT,  TGT_KEYS,   16'd1,     16'd0,     16'd0,     8'd17));
        opening.push_back(make_cmd(OP_TICK,    TGT_SCREEN, 16'd0,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_BRIGHT,  TGT_BOTH,   16'd0,     16'd0,     16'd0,     8'd255));
        opening.push_back(make_cmd(OP_BRIGHT,  TGT_SCREEN, 16'd9,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_BLINK,   TGT_BOTH,   16'hFFFF,  16'hFFFF,  16'hFFFF,  8'd0));
        opening.push_back(make_cmd(OP_ON,      TGT_SCREEN, 16'd0,     16'd0,     16'd0,     8'd0));
        opening.push_back(make_cmd(OP_TOGGLE,  TGT_KEYS,   16'hFFFF,  16'd0,     16'd0,     8'd0));
        foreach (opening[i]) send_command(opening[i]);

        // Random part
        repeat (RANDOM_COMMANDS) send_command(random_command());
        i_valid = 1'b0;

        // Drain: wait for every predicted report, then watch for extras.
        while (lamp_sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands (%0d ticks, %0d error reports), %0d reports checked",
                 lamp_sb.commands_taken, lamp_sb.ticks_taken, lamp_sb.error_reports,
                 lamp_sb.reports_checked);
        $display("Saw %0d blink flips and %0d override reverts; %0d mismatches",
                 lamp_sb.blink_flips, lamp_sb.override_reverts, lamp_sb.mismatches);
        if (lamp_sb.mismatches == 0 && lamp_sb.pending_count() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/dbtbc_pkg.sv
rtl/dbtbc_chan.sv
rtl/dual_backlight_timed_blink_ctrl_top.sv
tb/backlight_check_pkg.sv
tb/tb.sv
